FILE: rtl/hlfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_pkg
// Shared types and constants of the header/length frame receiver: the
// command that passes from the front end to the burst engine, and the
// buffer bank release that comes back.
// ----------------------------------------------------------------------------
package hlfr_pkg;

  localparam int LEN_W      = 7;
  localparam int SLOT_OUT_W = 3;
  localparam int CMD_DEPTH  = 2;

  typedef struct packed {
    logic                  echo;
    logic [7:0]            data;
    logic                  bank;
    logic [LEN_W-1:0]      len;
    logic [SLOT_OUT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

FILE: rtl/hlfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while read enable is low.
// ----------------------------------------------------------------------------
module hlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/hlfr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_cmd_fifo
// Short command queue between the front end and the burst engine.
// ----------------------------------------------------------------------------
module hlfr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hlfr_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output hlfr_pkg::cmd_t dout,
  output logic           empty
);

  localparam int DEPTH = hlfr_pkg::CMD_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hlfr_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/hlfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_front
// Receive front end: configuration registers, header hunt, length capture,
// frame assembly into a two-bank buffer, and command issue for echoes and
// completed frames.
// ----------------------------------------------------------------------------
module hlfr_front #(
  parameter int MAX_FRAME_LEN = 32,
  parameter int FRAME_SLOTS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [1:0]                           wr_index,
  input  logic [7:0]                           wr_data,
  input  logic                                 push,
  output logic                                 full,
  input  logic [7:0]                           rx_byte,
  output logic                                 q_push,
  output hlfr_pkg::cmd_t                       q_din,
  input  logic                                 q_full,
  input  hlfr_pkg::release_t                   rel,
  output logic                                 mem_we,
  output logic [$clog2(MAX_FRAME_LEN):0]       mem_waddr,
  output logic [7:0]                           mem_wdata
);

  localparam int IDX_W  = $clog2(MAX_FRAME_LEN);
  localparam int POS_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int SUM_W  = (POS_W > 9) ? POS_W : 9;

  localparam logic [1:0] REG_LOOPBACK = 2'd0;
  localparam logic [1:0] REG_FIRST    = 2'd1;
  localparam logic [1:0] REG_SECOND   = 2'd2;
  localparam logic [1:0] REG_EXTRA    = 2'd3;

  logic              loopback_mode;
  logic [7:0]        first_header;
  logic [7:0]        second_header;
  logic [7:0]        length_extra;
  logic [POS_W-1:0]  fill_position;
  logic [POS_W-1:0]  fill_position_next;
  logic [POS_W-1:0]  expected_length;
  logic [POS_W-1:0]  expected_length_next;
  logic [SLOT_W-1:0] slot_counter;
  logic [SLOT_W-1:0] slot_counter_next;
  logic              wbank;
  logic              wbank_next;
  logic [1:0]        bank_busy;
  logic [1:0]        bank_set;
  logic              accept;
  logic [SUM_W-1:0]  want_sum;
  logic [POS_W-1:0]  fill_inc;
  logic [SLOT_W+2:0] slot_ext;

  assign full      = q_full || (!loopback_mode && bank_busy[wbank]);
  assign accept    = push && !full;
  assign want_sum  = SUM_W'(rx_byte) + SUM_W'(length_extra);
  assign fill_inc  = fill_position + POS_W'(1);
  assign slot_ext  = {3'b000, slot_counter};
  assign mem_wdata = rx_byte;
  assign mem_waddr = {wbank, fill_position[IDX_W-1:0]};

  always_comb begin
    fill_position_next   = fill_position;
    expected_length_next = expected_length;
    slot_counter_next    = slot_counter;
    wbank_next           = wbank;
    bank_set             = 2'b00;
    mem_we               = 1'b0;
    q_push               = 1'b0;
    q_din.echo           = 1'b0;
    q_din.data           = rx_byte;
    q_din.bank           = wbank;
    q_din.len            = hlfr_pkg::LEN_W'(fill_inc);
    q_din.slot           = slot_ext[2:0];
    if (accept) begin
      if (loopback_mode) begin
        q_push     = 1'b1;
        q_din.echo = 1'b1;
      end else if (fill_position == POS_W'(0)) begin
        if (rx_byte == first_header) begin
          mem_we             = 1'b1;
          fill_position_next = POS_W'(1);
        end
      end else if (fill_position == POS_W'(1)) begin
        if (rx_byte == second_header) begin
          mem_we             = 1'b1;
          fill_position_next = POS_W'(2);
        end else begin
          fill_position_next = '0;
        end
      end else if (fill_position == POS_W'(2)) begin
        mem_we             = 1'b1;
        fill_position_next = POS_W'(3);
        if (want_sum > SUM_W'(MAX_FRAME_LEN)) begin
          expected_length_next = POS_W'(MAX_FRAME_LEN);
        end else begin
          expected_length_next = want_sum[POS_W-1:0];
        end
      end else if (fill_position >= POS_W'(MAX_FRAME_LEN)) begin
        fill_position_next = '0;
      end else begin
        mem_we             = 1'b1;
        fill_position_next = fill_inc;
        if (fill_inc >= expected_length) begin
          q_push             = 1'b1;
          fill_position_next = '0;
          wbank_next         = !wbank;
          bank_set[wbank]    = 1'b1;
          if (slot_counter == SLOT_W'(FRAME_SLOTS - 1)) begin
            slot_counter_next = '0;
          end else begin
            slot_counter_next = slot_counter + SLOT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loopback_mode   <= 1'b0;
      first_header    <= '0;
      second_header   <= '0;
      length_extra    <= '0;
      fill_position   <= '0;
      expected_length <= POS_W'(MAX_FRAME_LEN);
      slot_counter    <= '0;
      wbank           <= 1'b0;
      bank_busy       <= 2'b00;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_LOOPBACK: loopback_mode <= wr_data[0];
          REG_FIRST:    first_header  <= wr_data;
          REG_SECOND:   second_header <= wr_data;
          REG_EXTRA:    length_extra  <= wr_data;
          default:      ;
        endcase
      end
      fill_position   <= fill_position_next;
      expected_length <= expected_length_next;
      slot_counter    <= slot_counter_next;
      wbank           <= wbank_next;
      for (int b = 0; b < 2; b++) begin
        if (bank_set[b]) begin
          bank_busy[b] <= 1'b1;
        end else if (rel.valid && (rel.bank == 1'(b))) begin
          bank_busy[b] <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/hlfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_back
// Burst engine: takes commands from the queue, reads completed frames out
// of the buffer one byte at a time, and holds the result register.
// ----------------------------------------------------------------------------
module hlfr_back #(
  parameter int MAX_FRAME_LEN = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hlfr_pkg::cmd_t                   q_dout,
  input  logic                             q_empty,
  output logic                             q_pop,
  output logic                             mem_re,
  output logic [$clog2(MAX_FRAME_LEN):0]   mem_raddr,
  input  logic [7:0]                       mem_rdata,
  output hlfr_pkg::release_t               rel,
  output logic                             empty,
  input  logic                             pop,
  output logic                             kind,
  output logic [7:0]                       data_byte,
  output logic [4:0]                       byte_index,
  output logic [5:0]                       frame_length,
  output logic [2:0]                       slot,
  output logic                             last
);

  localparam int IDX_W = $clog2(MAX_FRAME_LEN);
  localparam int LEN_W = hlfr_pkg::LEN_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t           state;
  hlfr_pkg::cmd_t   cur;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] idx_inc;
  logic             out_valid;
  logic             out_free;
  logic             is_last;

  assign out_free  = !out_valid || pop;
  assign idx_inc   = idx + LEN_W'(1);
  assign is_last   = (idx_inc == cur.len);
  assign empty     = !out_valid;
  assign mem_re    = (state == ST_READ);
  assign mem_raddr = {cur.bank, idx[IDX_W-1:0]};
  assign rel.valid = (state == ST_LOAD) && out_free && is_last;
  assign rel.bank  = cur.bank;
  assign q_pop     = (state == ST_IDLE) && !q_empty && (!q_dout.echo || out_free);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_dout;
      idx <= '0;
    end else if ((state == ST_LOAD) && out_free) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && q_pop && q_dout.echo) begin
      kind         <= 1'b1;
      data_byte    <= q_dout.data;
      byte_index   <= '0;
      frame_length <= '0;
      slot         <= '0;
      last         <= 1'b1;
    end else if ((state == ST_LOAD) && out_free) begin
      kind         <= 1'b0;
      data_byte    <= mem_rdata;
      byte_index   <= idx[4:0];
      frame_length <= cur.len[5:0];
      slot         <= cur.slot;
      last         <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_dout.echo) begin
              out_valid <= 1'b1;
            end else begin
              state <= ST_READ;
              if (pop) begin
                out_valid <= 1'b0;
              end
            end
          end else if (pop) begin
            out_valid <= 1'b0;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
          if (pop) begin
            out_valid <= 1'b0;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= is_last ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/header_length_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_frame_receiver
// Two-byte-header, length-prefixed frame receiver with loopback echo.
//
// Input channel: rx_byte is taken at a clock edge with push high and full
// low. Result channel: while empty is low the oldest result sits on kind,
// data_byte, byte_index, frame_length, slot and last; pop takes it.
// Configuration: wr_en, wr_index, wr_data write one register per cycle
// (0 loopback, 1 first header, 2 second header, 3 length extra); write only
// while the block is idle.
// Loopback: each byte becomes one echo beat, shown after the command queue
// and result register; one byte per cycle is accepted while the queue has
// room. Frames: bytes are accepted one per cycle into a two-bank buffer;
// the burst of a completed frame starts once its command leaves the queue
// and delivers one beat at a time, each through the buffer read followed
// by the result register load. A new frame fills the other bank meanwhile;
// full rises when the bank it needs is still being read out.
// Reset clears the settings, the hunt state and the queues; no clearing
// pass. A stalled result side holds the result and backs up into full.
// ----------------------------------------------------------------------------
module header_length_frame_receiver #(
  parameter int MAX_FRAME_LEN = 32,
  parameter int FRAME_SLOTS   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [4:0] byte_index,
  output logic [5:0] frame_length,
  output logic [2:0] slot,
  output logic       last
);

  localparam int AW = $clog2(MAX_FRAME_LEN) + 1;

  hlfr_pkg::cmd_t     q_din;
  hlfr_pkg::cmd_t     q_dout;
  hlfr_pkg::release_t rel;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  hlfr_front #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN),
    .FRAME_SLOTS  (FRAME_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .full     (full),
    .rx_byte  (rx_byte),
    .q_push   (q_push),
    .q_din    (q_din),
    .q_full   (q_full),
    .rel      (rel),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

  hlfr_cmd_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  hlfr_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  hlfr_back #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_dout      (q_dout),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .rel         (rel),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .frame_length(frame_length),
    .slot        (slot),
    .last        (last)
  );

endmodule
